FILE: design/ebfc_pkg.sv
package ebfc_pkg;

  // Fixed field widths
  localparam int CFG_DATA_W  = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int RATE_W      = 32;
  localparam int INIT_LVL_W  = 48;
  localparam int MAX_LVL_W   = 47;
  localparam int OUT_LVL_W   = 48;

  // Parameter defaults
  localparam int DEFAULT_TIME_WIDTH  = 32;
  localparam int DEFAULT_LEVEL_WIDTH = 48;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LEVEL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START_TIME = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESTORE_RATE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONSUME_RATE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP_COST      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL         = 3'd5;

  typedef struct packed {
    logic [INIT_LVL_W-1:0] initial_level;
    logic [RATE_W-1:0]     window_start_time;
    logic [RATE_W-1:0]     restore_rate;
    logic [RATE_W-1:0]     consume_rate;
    logic [RATE_W-1:0]     startup_cost;
    logic [MAX_LVL_W-1:0]  max_level;
  } cfg_t;

endpackage

FILE: design/ebfc_cfg.sv
module ebfc_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [ebfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ebfc_pkg::CFG_DATA_W-1:0] cfg_data,
  output ebfc_pkg::cfg_t                  cfg
);
  import ebfc_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_INITIAL_LEVEL:     regs.initial_level     <= cfg_data[INIT_LVL_W-1:0];
        REG_WINDOW_START_TIME: regs.window_start_time <= cfg_data[RATE_W-1:0];
        REG_RESTORE_RATE:      regs.restore_rate      <= cfg_data[RATE_W-1:0];
        REG_CONSUME_RATE:      regs.consume_rate      <= cfg_data[RATE_W-1:0];
        REG_STARTUP_COST:      regs.startup_cost      <= cfg_data[RATE_W-1:0];
        REG_MAX_LEVEL:         regs.max_level         <= cfg_data[MAX_LVL_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign cfg = regs;

endmodule

FILE: design/energy_budget_feasibility_check_top.sv
// Channel  Handshake            Payload
// -------  -------------------  ------------------------------------------
// in       in_valid / in_ready  task_start, task_end, last_task
// out      out_valid/out_ready  level_after, feasible, schedule_done
// cfg      cfg_write            cfg_index, cfg_data (no wait, no read-back)
//
// One request per cycle sustained unless out_ready stalls the output. Each
// request crosses five registers: the input stage, a span stage (idle gap and
// task duration), a product stage (two multipliers), a prep stage, and then
// the result register, which also holds the running level.
// Bubbles collapse: a stage loads whenever it is empty or its successor moves,
// so requests are taken while a finished result waits for out_ready.
// Reset (rst, synchronous) empties the pipeline, zeroes the registers and arms
// a schedule start, which loads level and time from the registers.
module energy_budget_feasibility_check_top #(
  parameter int TIME_WIDTH  = ebfc_pkg::DEFAULT_TIME_WIDTH,
  parameter int LEVEL_WIDTH = ebfc_pkg::DEFAULT_LEVEL_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // task requests
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [TIME_WIDTH-1:0]                  task_start,
  input  logic [TIME_WIDTH-1:0]                  task_end,
  input  logic                                   last_task,
  // results
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [ebfc_pkg::OUT_LVL_W-1:0]  level_after,
  output logic                                   feasible,
  output logic                                   schedule_done,
  // register writes
  input  logic                                   cfg_write,
  input  logic [ebfc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ebfc_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import ebfc_pkg::*;

  // Span: signed difference of two times. Product: Q16.16 rate times span.
  localparam int GW  = TIME_WIDTH + 1;
  localparam int PW  = RATE_W + 1 + GW;
  localparam int SW0 = (LEVEL_WIDTH > PW + 1) ? LEVEL_WIDTH : PW + 1;
  localparam int SW  = SW0 + 2;  // room for any unsaturated sum
  localparam int LW  = LEVEL_WIDTH;
  localparam int EW  = TIME_WIDTH + RATE_W;

  localparam logic signed [SW-1:0] LMAX = {{(SW-LW+1){1'b0}}, {(LW-1){1'b1}}};
  localparam logic signed [SW-1:0] LMIN = {{(SW-LW+1){1'b1}}, {(LW-1){1'b0}}};

  function automatic logic signed [LW-1:0] sat_lvl(input logic signed [SW-1:0] x);
    logic signed [LW-1:0] r;
    if (x > LMAX)      r = LMAX[LW-1:0];
    else if (x < LMIN) r = LMIN[LW-1:0];
    else               r = x[LW-1:0];
    return r;
  endfunction

  function automatic logic signed [SW-1:0] ext_lvl(input logic signed [LW-1:0] x);
    return {{(SW-LW){x[LW-1]}}, x};
  endfunction

  cfg_t cfg;

  ebfc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // ---------------- stage enables (bubble collapsing) ----------------
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en_out;

  assign en_out   = !out_valid || out_ready;
  assign en4      = !v4 || en_out;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1)    v1        <= in_valid;
      if (en2)    v2        <= v1;
      if (en3)    v3        <= v2;
      if (en4)    v4        <= v3;
      if (en_out) out_valid <= v4;
    end
  end

  // ---------------- stage 1: input register ----------------
  logic [TIME_WIDTH-1:0] ts1, te1;
  logic                  last1;

  always_ff @(posedge clk) begin
    if (en1) begin
      ts1   <= task_start;
      te1   <= task_end;
      last1 <= last_task;
    end
  end

  // ---------------- stage 2: spans ----------------
  // Time tracking follows request order, so it lives at the stage 1 exit.
  logic                  start_pending;  // next request opens a schedule
  logic [TIME_WIDTH-1:0] prev_te;
  logic [EW-1:0]         wst_ext;
  logic [TIME_WIDTH-1:0] cur_time;

  assign wst_ext  = {{TIME_WIDTH{1'b0}}, cfg.window_start_time};
  assign cur_time = start_pending ? wst_ext[TIME_WIDTH-1:0] : prev_te;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pending <= 1'b1;
    end else if (v1 && en2) begin
      start_pending <= last1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && en2) prev_te <= te1;
  end

  logic signed [GW-1:0] gap2, dur2;
  logic                 last2, fresh2;

  always_ff @(posedge clk) begin
    if (en2) begin
      gap2   <= $signed({1'b0, ts1}) - $signed({1'b0, cur_time});
      dur2   <= $signed({1'b0, te1}) - $signed({1'b0, ts1});
      last2  <= last1;
      fresh2 <= start_pending;
    end
  end

  // ---------------- stage 3: products ----------------
  logic signed [RATE_W:0] restore_s, net_rate;
  assign restore_s = $signed({1'b0, cfg.restore_rate});
  assign net_rate  = restore_s - $signed({1'b0, cfg.consume_rate});

  logic signed [PW-1:0] recharge3, drain3;
  logic                 last3, fresh3;

  always_ff @(posedge clk) begin
    if (en3) begin
      recharge3 <= restore_s * gap2;
      drain3    <= net_rate * dur2;
      last3     <= last2;
      fresh3    <= fresh2;
    end
  end

  // ---------------- stage 4: level-independent prep ----------------
  // tail = net change minus startup cost; floor_lvl covers the case where the
  // startup cost hits the lower bound first.
  logic signed [SW-1:0] startup_w, recharge_w, drain_w;
  assign startup_w  = $signed({{(SW-RATE_W){1'b0}}, cfg.startup_cost});
  assign recharge_w = {{(SW-PW){recharge3[PW-1]}}, recharge3};
  assign drain_w    = {{(SW-PW){drain3[PW-1]}}, drain3};

  logic signed [SW-1:0] recharge4, tail4;
  logic signed [LW-1:0] floor_lvl4;
  logic                 last4, fresh4;

  always_ff @(posedge clk) begin
    if (en4) begin
      recharge4  <= recharge_w;
      tail4      <= drain_w - startup_w;
      floor_lvl4 <= sat_lvl(LMIN + drain_w);
      last4      <= last3;
      fresh4     <= fresh3;
    end
  end

  // ---------------- result stage: running level ----------------
  logic signed [LW-1:0] level;
  logic                 failed;

  logic signed [SW-1:0] init_w, ceil_raw, ceil_w, thr_w, consume_w;
  logic signed [LW-1:0] load_lvl, base_lvl, charged, level_next;
  logic signed [SW-1:0] charged_w, capped_w, level_next_w;
  logic                 failed_next;

  always_comb begin
    init_w    = $signed({{(SW-INIT_LVL_W){cfg.initial_level[INIT_LVL_W-1]}},
                         cfg.initial_level});
    load_lvl  = sat_lvl(init_w);
    ceil_raw  = $signed({{(SW-MAX_LVL_W){1'b0}}, cfg.max_level});
    ceil_w    = (ceil_raw > LMAX) ? LMAX : ceil_raw;
    thr_w     = LMIN + startup_w;
    consume_w = $signed({{(SW-RATE_W){1'b0}}, cfg.consume_rate});

    base_lvl  = fresh4 ? load_lvl : level;
    // recharge over the idle gap, then clamp at the ceiling
    charged   = sat_lvl(ext_lvl(base_lvl) + recharge4);
    charged_w = ext_lvl(charged);
    capped_w  = (charged_w < ceil_w) ? charged_w : ceil_w;
    // startup cost and net rate over the task
    if (capped_w < thr_w) level_next = floor_lvl4;
    else                  level_next = sat_lvl(capped_w + tail4);
    level_next_w = ext_lvl(level_next);

    failed_next = (fresh4 ? 1'b0 : failed) || (level_next_w < consume_w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      failed <= 1'b0;
    end else if (v4 && en_out) begin
      failed <= failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (v4 && en_out) level <= level_next;
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      level_after   <= level_next_w[OUT_LVL_W-1:0];
      feasible      <= !failed_next;
      schedule_done <= last4;
    end
  end

endmodule
